/* rtl/debounced_four_key_hid_report_macros.svh */
// Assertion macros shared by the four-key HID report block.
`ifndef DEBOUNCED_FOUR_KEY_HID_REPORT_MACROS_SVH
`define DEBOUNCED_FOUR_KEY_HID_REPORT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DFKHID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DFKHID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dfkhid_pkg.sv */
// Types and constants for the four-key HID report block.
`default_nettype none

package dfkhid_pkg;

  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 8;

  localparam logic [7:0] CODE_UP_RST     = 8'h52;
  localparam logic [7:0] CODE_DOWN_RST   = 8'h51;
  localparam logic [7:0] CODE_ENTER_RST  = 8'h28;
  localparam logic [7:0] CODE_ESCAPE_RST = 8'h29;
  localparam logic [7:0] SETTLE_RST      = 8'd5;

  typedef enum logic [CFG_AW-1:0] {
    CFG_CODE_UP     = 3'd0,
    CFG_CODE_DOWN   = 3'd1,
    CFG_CODE_ENTER  = 3'd2,
    CFG_CODE_ESCAPE = 3'd3,
    CFG_SETTLE      = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    MODE_POLL       = 1'b0,
    MODE_GET_REPORT = 1'b1
  } mode_t;

  typedef struct packed {
    logic       mode;
    logic [3:0] pins;
    logic       host_ready;
    logic       timer_tick;
  } in_item_t;

  typedef struct packed {
    logic [7:0] slot_up;
    logic [7:0] slot_down;
    logic [7:0] slot_enter;
    logic [7:0] slot_escape;
    logic       via_control;
  } out_item_t;

  typedef struct packed {
    logic [7:0] code_up;
    logic [7:0] code_down;
    logic [7:0] code_enter;
    logic [7:0] code_escape;
    logic [7:0] settle_ticks;
  } cfg_t;

  // Step result handed from the engine to the output stage.
  typedef struct packed {
    logic      emit;
    out_item_t report;
  } step_res_t;

endpackage

`default_nettype wire

/* rtl/debounced_four_key_hid_report.sv */
// Top level of the debounced four-key HID report block.
// A transaction is accepted into the input register, stepped from there,
// and its report, if any, waits in the output register until taken.
// Throughput: one transaction per cycle, set by the single-pass step logic;
// the input stalls only while a report waits in a stalled output register.
// Reset (rst_n low, synchronous): first scan sees all buttons as changed, a
// report is armed, scanning is on, codes and settle count take defaults.
`default_nettype none
`include "debounced_four_key_hid_report_macros.svh"

module debounced_four_key_hid_report
  import dfkhid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // poll / get-report channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // report channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // register writes
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  // Configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_up      <= CODE_UP_RST;
      cfg_r.code_down    <= CODE_DOWN_RST;
      cfg_r.code_enter   <= CODE_ENTER_RST;
      cfg_r.code_escape  <= CODE_ESCAPE_RST;
      cfg_r.settle_ticks <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_CODE_UP:     cfg_r.code_up      <= cfg_wdata;
        CFG_CODE_DOWN:   cfg_r.code_down    <= cfg_wdata;
        CFG_CODE_ENTER:  cfg_r.code_enter   <= cfg_wdata;
        CFG_CODE_ESCAPE: cfg_r.code_escape  <= cfg_wdata;
        CFG_SETTLE:      cfg_r.settle_ticks <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Input register: holds one transaction until the step logic takes it.
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      s1_adv;
  logic      in_accept;
  logic      fire;

  // The step may produce a report, so only advance when the output slot is
  // empty or being drained this cycle.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign fire      = s1_valid_r && s1_adv;

  always_comb begin
    priority if (in_accept) s1_valid_nxt = 1'b1;
    else if (s1_adv)        s1_valid_nxt = 1'b0;
    else                    s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_data_r <= in_data;
  end

  // Step logic and block state
  step_res_t step_res;

  dfkhid_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_data_r),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  always_comb begin
    priority if (fire && step_res.emit) out_valid_nxt = 1'b1;
    else if (!out_stall)                out_valid_nxt = 1'b0;
    else                                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire && step_res.emit) out_data_r <= step_res.report;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `DFKHID_ASSERT_NOW(a_stall_only_when_held, in_stall, s1_valid_r, "stall with empty input register")
  `DFKHID_ASSERT_NEXT(a_get_report_answers, fire && s1_data_r.mode, out_valid_r && out_data_r.via_control, "get-report gave no control answer")
  `DFKHID_ASSERT_NOW(a_no_overwrite, fire && step_res.emit, !out_valid_r || !out_stall, "report overwritten while stalled")

endmodule

`default_nettype wire

/* rtl/dfkhid_engine.sv */
// Scan, report build and settle counter state for the four-key HID block.
`default_nettype none

module dfkhid_engine
  import dfkhid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output step_res_t      res
);

  logic [NUM_KEYS-1:0] levels_r, levels_nxt;
  logic                known_r, known_nxt;
  logic [NUM_KEYS-1:0] changed_r, changed_nxt;
  logic                armed_r, armed_nxt;
  logic                scan_r, scan_nxt;
  logic [7:0]          ticks_r, ticks_nxt;
  logic [7:0]          slots_r [NUM_KEYS];
  logic [7:0]          slots_nxt [NUM_KEYS];
  logic [7:0]          codes [NUM_KEYS];

  assign codes[0] = cfg.code_up;
  assign codes[1] = cfg.code_down;
  assign codes[2] = cfg.code_enter;
  assign codes[3] = cfg.code_escape;

  always_comb begin
    logic [NUM_KEYS-1:0] diff;
    logic                do_build;
    levels_nxt  = levels_r;
    known_nxt   = known_r;
    changed_nxt = changed_r;
    armed_nxt   = armed_r;
    scan_nxt    = scan_r;
    ticks_nxt   = ticks_r;
    for (int k = 0; k < NUM_KEYS; k++) slots_nxt[k] = slots_r[k];
    diff        = '0;
    do_build    = 1'b0;
    res.emit    = 1'b0;

    unique case (mode_t'(item.mode))
      MODE_GET_REPORT: begin
        res.emit = 1'b1;
        do_build = armed_r;
      end
      MODE_POLL: begin
        if (scan_r) begin
          diff      = known_r ? (item.pins ^ levels_r) : '1;
          known_nxt = 1'b1;
          if (diff != '0) begin
            levels_nxt  = item.pins;
            changed_nxt = changed_r | diff;
            scan_nxt    = 1'b0;
            armed_nxt   = 1'b1;
          end
        end
        if (item.host_ready && armed_nxt) begin
          res.emit = 1'b1;
          do_build = 1'b1;
        end
        // tick count is not cleared on a change; compare after increment
        if (item.timer_tick) begin
          ticks_nxt = ticks_r + 8'd1;
          if (ticks_nxt >= cfg.settle_ticks) begin
            ticks_nxt = '0;
            scan_nxt  = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (do_build) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (changed_nxt[k]) slots_nxt[k] = levels_nxt[k] ? 8'd0 : codes[k];
      end
      changed_nxt = '0;
      armed_nxt   = 1'b0;
    end

    res.report.slot_up     = slots_nxt[0];
    res.report.slot_down   = slots_nxt[1];
    res.report.slot_enter  = slots_nxt[2];
    res.report.slot_escape = slots_nxt[3];
    res.report.via_control = item.mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r  <= '0;
      known_r   <= 1'b0;
      changed_r <= '0;
      armed_r   <= 1'b1;
      scan_r    <= 1'b1;
      ticks_r   <= '0;
      for (int k = 0; k < NUM_KEYS; k++) slots_r[k] <= '0;
    end else if (fire) begin
      levels_r  <= levels_nxt;
      known_r   <= known_nxt;
      changed_r <= changed_nxt;
      armed_r   <= armed_nxt;
      scan_r    <= scan_nxt;
      ticks_r   <= ticks_nxt;
      for (int k = 0; k < NUM_KEYS; k++) slots_r[k] <= slots_nxt[k];
    end
  end

endmodule

`default_nettype wire

/* verif/debounced_four_key_hid_report_tb.sv */
// Self-checking testbench for the debounced four-key HID report block.
`default_nettype none

module debounced_four_key_hid_report_tb;
  import dfkhid_pkg::*;

  localparam int LIMIT       = 1000000; // cycle budget for the whole run
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int TAIL_CYCLES = 8;       // tail wait after the last predicted report

  // Predicts the reports the block emits and checks them in order.
  // The key state (latched levels, change flags, arming, scan/tick debounce
  // and the report slots) is kept here and stepped once per accepted transaction.
  class key_report_scoreboard;
    logic [7:0] key_codes [NUM_KEYS];
    logic [7:0] settle_ticks;
    logic [3:0] latched_pins;
    bit         levels_known;
    logic [3:0] changed;
    bit         armed;
    bit         scanning;
    logic [7:0] tick_count;
    logic [7:0] slots [NUM_KEYS];
    out_item_t  pending_reports [$];
    int         errors;

    function new();
      key_codes    = '{CODE_UP_RST, CODE_DOWN_RST, CODE_ENTER_RST, CODE_ESCAPE_RST};
      settle_ticks = SETTLE_RST;
      latched_pins = '0;
      levels_known = 1'b0;
      changed      = '0;
      armed        = 1'b1;
      scanning     = 1'b1;
      tick_count   = '0;
      slots        = '{default: 8'h00};
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [7:0] value);
      if (idx == CFG_SETTLE)
        settle_ticks = value;
      else
        key_codes[int'(idx)] = value;
    endfunction

    // Rewrite the changed slots of an armed report, then disarm.
    function void refresh_slots();
      if (!armed)
        return;
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (changed[k])
          slots[k] = latched_pins[k] ? 8'h00 : key_codes[k];
      end
      changed = '0;
      armed   = 1'b0;
    endfunction

    function out_item_t slot_snapshot(logic ctl);
      out_item_t r;
      r.slot_up     = slots[0];
      r.slot_down   = slots[1];
      r.slot_enter  = slots[2];
      r.slot_escape = slots[3];
      r.via_control = ctl;
      return r;
    endfunction

    // Note an accepted poll or get-report transaction.
    function void take_poll(in_item_t it);
      logic [3:0] diff;
      if (it.mode == MODE_GET_REPORT) begin
        refresh_slots();
        pending_reports.push_back(slot_snapshot(1'b1));
        return;
      end
      // scan
      if (scanning) begin
        diff = levels_known ? (it.pins ^ latched_pins) : 4'hF;
        levels_known = 1'b1;
        if (diff != 4'h0) begin
          latched_pins = it.pins;
          changed      = changed | diff;
          scanning     = 1'b0;
          armed        = 1'b1;
        end
      end
      // send
      if (it.host_ready && armed) begin
        refresh_slots();
        pending_reports.push_back(slot_snapshot(1'b0));
      end
      // debounce count: not cleared on a change, compared after the increment
      if (it.timer_tick) begin
        tick_count = tick_count + 8'd1;
        if (tick_count >= settle_ticks) begin
          tick_count = '0;
          scanning   = 1'b1;
        end
      end
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
      end
    endfunction

    // Check an accepted report against the oldest prediction.
    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none actual %h", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      field_check("slot_up",     want.slot_up,     got.slot_up);
      field_check("slot_down",   want.slot_down,   got.slot_down);
      field_check("slot_enter",  want.slot_enter,  got.slot_enter);
      field_check("slot_escape", want.slot_escape, got.slot_escape);
      field_check("via_control", 8'(want.via_control), 8'(got.via_control));
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = CFG_CODE_UP;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  key_report_scoreboard board = new();

  int         cycle_count = 0;
  int         hold_req    = 0;   // bumped by the stimulus to ask for a long hold-off
  int         hold_done   = 0;   // owned by the report sink
  bit         gaps_on     = 1'b1;
  int         tick_pct    = 50;
  int         ready_pct   = 60;
  logic [3:0] held_pins   = 4'hF;

  debounced_four_key_hid_report DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Watchdog: a correct run finishes far inside this budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both channels are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_report(out_data);
      if (in_valid && !in_stall)
        board.take_poll(in_data);
    end
  end

  // Report sink: runs of stall and no stall, mostly short, now and then long;
  // on request a long hold-off so the block backs up into its input.
  initial begin : report_sink
    int run_left;
    bit run_stall;
    int r;
    run_left  = 0;
    run_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_req) begin
        hold_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        run_left  = 0;
        run_stall = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            run_stall = 1'b0;
            run_left  = $urandom_range(1, 30);
          end else if (r < 88) begin
            run_stall = 1'b1;
            run_left  = $urandom_range(1, 3);
          end else if (r < 97) begin
            run_stall = 1'b1;
            run_left  = $urandom_range(4, 20);
          end else begin
            run_stall = 1'b1;
            run_left  = $urandom_range(30, 80);
          end
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  function automatic in_item_t key_item(logic m, logic [3:0] p, logic hr, logic tk);
    in_item_t it;
    it.mode       = m;
    it.pins       = p;
    it.host_ready = hr;
    it.timer_tick = tk;
    return it;
  endfunction

  // Mostly button-like traffic: levels held, one key flipping now and then,
  // with a sprinkling of noisy pin samples and get-report requests.
  function automatic in_item_t random_item();
    in_item_t it;
    if ($urandom_range(0, 99) < 20)
      held_pins = held_pins ^ (4'b0001 << $urandom_range(0, 3));
    if ($urandom_range(0, 99) < 3)
      held_pins = 4'($urandom);
    it.mode       = ($urandom_range(0, 99) < 10) ? MODE_GET_REPORT : MODE_POLL;
    it.pins       = ($urandom_range(0, 99) < 8) ? 4'($urandom) : held_pins;
    it.host_ready = ($urandom_range(0, 99) < ready_pct);
    it.timer_tick = ($urandom_range(0, 99) < tick_pct);
    return it;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_item(in_item_t it);
    int gap;
    int r;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r < 40)      gap = 0;
      else if (r < 80) gap = $urandom_range(1, 2);
      else if (r < 95) gap = $urandom_range(3, 8);
      else             gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  // Stop offering, wait for every predicted report, then let the pipe empty
  // of transactions that produce nothing. The first edge lets the monitor
  // note the last accepted transaction before the queue is looked at.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    in_item_t   directed [$];
    logic [7:0] code;
    logic [7:0] settle;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, settle count of five.
    directed.push_back(key_item(MODE_GET_REPORT, 4'h0, 1'b1, 1'b1)); // before any scan
    directed.push_back(key_item(MODE_POLL, 4'hF, 1'b0, 1'b0));       // first scan: all changed
    directed.push_back(key_item(MODE_POLL, 4'hF, 1'b1, 1'b0));       // all-released report
    directed.push_back(key_item(MODE_POLL, 4'h0, 1'b1, 1'b0));       // nothing armed
    repeat (5)
      directed.push_back(key_item(MODE_POLL, 4'h0, 1'b0, 1'b1));     // count up to settle
    directed.push_back(key_item(MODE_POLL, 4'h0, 1'b1, 1'b0));       // all pressed
    directed.push_back(key_item(MODE_GET_REPORT, 4'hF, 1'b0, 1'b0)); // unarmed get-report
    directed.push_back(key_item(MODE_POLL, 4'b1110, 1'b0, 1'b1));    // change ignored, scan off
    directed.push_back(key_item(MODE_POLL, 4'b0101, 1'b1, 1'b1));
    repeat (3)
      directed.push_back(key_item(MODE_POLL, 4'b0101, 1'b0, 1'b1));
    directed.push_back(key_item(MODE_POLL, 4'b0101, 1'b0, 1'b0));    // partial change armed
    directed.push_back(key_item(MODE_GET_REPORT, 4'hF, 1'b0, 1'b1)); // get-report disarms
    directed.push_back(key_item(MODE_POLL, 4'hF, 1'b1, 1'b1));       // so nothing here
    foreach (directed[i])
      send_item(directed[i]);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: begin code = 8'h00; settle = 8'd1;   end
        1: begin code = 8'hFF; settle = 8'd255; end
        5: begin code = 8'($urandom); settle = 8'($urandom_range(1, 255)); end
        default: begin code = 8'($urandom); settle = 8'($urandom_range(1, 6)); end
      endcase
      for (int k = 0; k < NUM_KEYS; k++)
        write_reg(cfg_idx_t'(k), (p < 2) ? code : 8'($urandom));
      write_reg(CFG_SETTLE, settle);
      cfg_we <= 1'b0;

      gaps_on   = (p != 2) && (p != 6);
      tick_pct  = (settle > 8'd20) ? 95 : $urandom_range(20, 70);
      ready_pct = $urandom_range(40, 90);

      if (p == 4) begin
        // Long receiver hold-off while the sender streams report requests.
        hold_req++;
        gaps_on = 1'b0;
        repeat (60)
          send_item(($urandom_range(0, 2) != 0) ?
                    key_item(MODE_GET_REPORT, 4'($urandom), 1'($urandom), 1'($urandom)) :
                    random_item());
        gaps_on = 1'b1;
      end

      repeat (200)
        send_item(random_item());
    end

    drain();
    if (board.errors == 0 && board.pending_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* debounced_four_key_hid_report.f */
+incdir+rtl
rtl/dfkhid_pkg.sv
rtl/dfkhid_engine.sv
rtl/debounced_four_key_hid_report.sv
verif/debounced_four_key_hid_report_tb.sv
